/* rtl/frame_mean_change_detector_unit_assert.svh */
// assertion macros for the frame mean change detector
// used by frame_mean_change_detector_unit; expects clk_i and rst_ni in scope
`ifndef FRAME_MEAN_CHANGE_DETECTOR_UNIT_ASSERT_SVH
`define FRAME_MEAN_CHANGE_DETECTOR_UNIT_ASSERT_SVH

// checked property, off while reset is asserted
`define FMCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked property, also during reset
`define FMCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/fmcd_pkg.sv */
// shared types and constants for the frame mean change detector
// no dependencies
`timescale 1ns / 1ps

package fmcd_pkg;

  // width of the per-frame pixel index counter
  localparam int unsigned IdxW    = 16;
  localparam int unsigned PixW    = 8;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned AvgW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW = 1;
  // common width for comparing the index against the averaging limit
  localparam int unsigned CmpW    = (IdxW > AvgW) ? IdxW : AvgW;
  localparam int unsigned CntW    = $clog2(PixW);

  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  // reset values of the configuration registers
  localparam logic [ThrW-1:0] ThrReset = ThrW'(10);
  localparam logic [AvgW-1:0] AvgReset = AvgW'(9600);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANGE_THRESHOLD = 1'b0,
    CFG_AVERAGED_PIXELS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] frame_mean;
    logic            motion_detected;
  } out_item_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

endpackage

/* rtl/frame_mean_change_detector_unit.sv */
// frame mean change detector: running frame mean and motion flag
// depends on fmcd_pkg and frame_mean_change_detector_unit_assert.svh
`timescale 1ns / 1ps

// Takes one 8-bit grayscale pixel per item with an end-of-frame mark and keeps
// a running mean of the leading averaged_pixels pixels of each frame. On the
// end-of-frame pixel it delivers the mean and a flag that is set when the mean
// moved by more than change_threshold since the previous frame. A pixel that
// updates the mean is accepted and then passes through a shared restoring
// divider that produces one quotient bit per cycle of (pixel - mean) / index.
// The first pixel of a frame and pixels past the averaging limit skip the
// divider. An end-of-frame pixel then waits in the finish state, which loads
// the result register once any earlier result has been taken. The input is
// not ready while an item is in the divider or waiting to finish.
module frame_mean_change_detector_unit
  import fmcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // pixel items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  // frame results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  `include "frame_mean_change_detector_unit_assert.svh"

  state_e            state_q, state_d;
  logic [ThrW-1:0]   thr_q;
  logic [AvgW-1:0]   avg_q;
  logic [PixW-1:0]   mean_q, mean_d;
  logic [PixW-1:0]   prev_q;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              eof_q, eof_d;
  logic              neg_q, neg_d;
  logic [IdxW-1:0]   div_q, div_d;
  logic [PixW-1:0]   rem_q, rem_d;
  logic [PixW-1:0]   quo_q, quo_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              in_acc;
  logic              averaging;
  logic              out_free;
  logic [PixW:0]     trial;
  logic              fits;
  logic [PixW-1:0]   quo_fin;
  logic [PixW-1:0]   diff_abs;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // pixel still inside the averaged window
  assign averaging = (CmpW'(idx_q) < CmpW'(avg_q)) && (idx_q != IdxMax);

  // one restoring divider step
  assign trial   = {rem_q, quo_q[PixW-1]};
  assign fits    = (IdxW'(trial) >= div_q);
  assign quo_fin = {quo_q[PixW-2:0], fits};

  // absolute change of the mean between frames
  assign diff_abs = (mean_q >= prev_q) ? (mean_q - prev_q) : (prev_q - mean_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      avg_q <= AvgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANGE_THRESHOLD: thr_q <= cfg_data_i[ThrW-1:0];
        CFG_AVERAGED_PIXELS:  avg_q <= cfg_data_i[AvgW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath next state
  always_comb begin
    state_d = state_q;
    mean_d  = mean_q;
    idx_d   = idx_q;
    eof_d   = eof_q;
    neg_d   = neg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          eof_d = in_item_i.end_of_frame;
          if (idx_q != IdxMax) begin
            idx_d = idx_q + IdxW'(1);
          end
          if (idx_q == '0) begin
            mean_d  = in_item_i.pixel;
            state_d = in_item_i.end_of_frame ? ST_FINISH : ST_IDLE;
          end else if (averaging) begin
            // start dividing the magnitude of pixel - mean by the index
            neg_d   = in_item_i.pixel < mean_q;
            quo_d   = neg_d ? (mean_q - in_item_i.pixel) : (in_item_i.pixel - mean_q);
            rem_d   = '0;
            div_d   = idx_q;
            cnt_d   = '0;
            state_d = ST_DIVIDE;
          end else begin
            state_d = in_item_i.end_of_frame ? ST_FINISH : ST_IDLE;
          end
        end
      end
      ST_DIVIDE: begin
        rem_d = fits ? PixW'(IdxW'(trial) - div_q) : trial[PixW-1:0];
        quo_d = quo_fin;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(PixW - 1)) begin
          // quotient complete, apply truncated step to the mean
          mean_d  = neg_q ? (mean_q - quo_fin) : (mean_q + quo_fin);
          state_d = eof_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      mean_q  <= '0;
      prev_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      mean_q  <= mean_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_FINISH && out_free) begin
        prev_q <= mean_q;
      end
    end
  end

  // divider payload registers
  always_ff @(posedge clk_i) begin
    eof_q <= eof_d;
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FINISH && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_item_q.frame_mean      <= mean_q;
      out_item_q.motion_detected <= diff_abs > thr_q;
    end
  end

  // checks
  `FMCD_ASSERT(a_div_nonzero, (state_q == ST_DIVIDE) |-> (div_q != '0), "divider by zero")
  `FMCD_ASSERT(a_rem_below, (state_q == ST_DIVIDE) |-> (IdxW'(rem_q) < div_q), "remainder too large")
  `FMCD_ASSERT(a_div_ends, (state_q == ST_DIVIDE && cnt_q == CntW'(PixW - 1)) |=> (state_q == ST_IDLE || state_q == ST_FINISH), "divide did not end")
  `FMCD_ASSERT(a_finish_out, (state_q == ST_FINISH && out_free) |=> (out_valid_o && idx_q == '0), "frame end lost")

endmodule
